// File: rtl/core/pee_pkg.sv
`default_nettype none

package pee_pkg;

  localparam int unsigned WORD_WIDTH_DEF = 32;
  localparam int unsigned FIFO_DEPTH_DEF = 4;

  localparam int unsigned OPERAND_W = 32;
  localparam int unsigned MODE_W    = 3;

  // mode codes on the input channel
  localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
  localparam logic [MODE_W-1:0] MODE_EQ  = 3'd4;

  // pending product-level operation
  localparam logic [1:0] PMUL_NONE = 2'd0;
  localparam logic [1:0] PMUL_MUL  = 2'd1;
  localparam logic [1:0] PMUL_DIV  = 2'd2;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_EQ
  } op_e;

  typedef struct packed {
    logic signed [OPERAND_W-1:0] operand;
    logic [MODE_W-1:0]           mode;
  } in_item_t;

  typedef struct packed {
    logic signed [OPERAND_W-1:0] result;
    logic                        div_by_zero;
  } out_item_t;

  typedef struct packed {
    logic signed [OPERAND_W-1:0] operand;
    op_e                         op;
  } token_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/pee_front.sv
`default_nettype none

module pee_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pee_pkg::in_item_t  in_item_i,
  input  pee_pkg::fifo_stat_t fifo_stat_i,
  output logic               push_o,
  output pee_pkg::token_t    push_tok_o
);
  import pee_pkg::*;

  logic known;
  op_e  op;

  always_comb begin
    known = 1'b1;
    op    = OP_ADD;
    unique case (in_item_i.mode)
      MODE_ADD: op = OP_ADD;
      MODE_SUB: op = OP_SUB;
      MODE_MUL: op = OP_MUL;
      MODE_DIV: op = OP_DIV;
      MODE_EQ:  op = OP_EQ;
      default:  known = 1'b0;
    endcase
  end

  assign in_stall_o = fifo_stat_i.full;

  // items with an unknown mode are taken and dropped here
  assign push_o             = in_valid_i && !fifo_stat_i.full && known;
  assign push_tok_o.operand = in_item_i.operand;
  assign push_tok_o.op      = op;

endmodule

`default_nettype wire

// File: rtl/core/pee_fifo.sv
`default_nettype none

module pee_fifo #(
  parameter int unsigned Depth = pee_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pee_pkg::token_t     push_tok_i,
  input  logic                pop_i,
  output pee_pkg::token_t     pop_tok_o,
  output pee_pkg::fifo_stat_t stat_o
);
  import pee_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  token_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_tok_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pee_back.sv
`default_nettype none

module pee_back #(
  parameter int unsigned WordWidth = pee_pkg::WORD_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tok_valid_i,
  input  pee_pkg::token_t    tok_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pee_pkg::out_item_t out_item_o
);
  import pee_pkg::*;

  localparam int unsigned W    = WordWidth;
  localparam int unsigned CntW = $clog2(W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SGN  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [W-1:0]    sum_q, sum_d;
  logic            sub_q, sub_d;
  logic [W-1:0]    term_q, term_d;
  logic [1:0]      pmul_q, pmul_d;
  logic            dz_q, dz_d;
  op_e             cur_op_q, cur_op_d;
  logic [W-1:0]    tres_q, tres_d;
  logic [W-1:0]    a_q, a_d;
  logic [W-1:0]    b_q, b_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    md_q, md_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_item_q, out_item_d;

  logic [W+31:0]   op_ext;
  logic [W-1:0]    v;
  logic [W-1:0]    v_mag, t_mag;
  logic [W:0]      rem_sh, rem_sub;
  logic            ge;
  logic [W-1:0]    sum_n;
  logic [W+31:0]   res_ext;
  logic            out_free;
  logic            last_step;

  assign op_ext    = {{W{tok_i.operand[OPERAND_W-1]}}, tok_i.operand};
  assign v         = op_ext[W-1:0];
  assign v_mag     = v[W-1] ? (W'(0) - v) : v;
  assign t_mag     = term_q[W-1] ? (W'(0) - term_q) : term_q;

  // restoring divide step: one quotient bit per cycle
  assign rem_sh    = {rem_q, b_q[W-1]};
  assign rem_sub   = rem_sh - {1'b0, md_q};
  assign ge        = !rem_sub[W];

  assign sum_n     = sub_q ? (sum_q - tres_q) : (sum_q + tres_q);
  assign res_ext   = {{32{sum_n[W-1]}}, sum_n};
  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_step = (cnt_q == CntW'(W - 1));

  assign pop_o       = (state_q == ST_IDLE) && tok_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    sub_d       = sub_q;
    term_d      = term_q;
    pmul_d      = pmul_q;
    dz_d        = dz_q;
    cur_op_d    = cur_op_q;
    tres_d      = tres_q;
    a_d         = a_q;
    b_d         = b_q;
    rem_d       = rem_q;
    md_d        = md_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;

    unique case (state_q)
      ST_IDLE: begin
        if (tok_valid_i) begin
          cur_op_d = tok_i.op;
          cnt_d    = '0;
          case (pmul_q)
            PMUL_MUL: begin
              a_d     = term_q;
              b_d     = v;
              tres_d  = '0;
              state_d = ST_MUL;
            end
            PMUL_DIV: begin
              if (v == '0) begin
                dz_d    = 1'b1;
                tres_d  = '0;
                state_d = ST_FIN;
              end else begin
                neg_d   = term_q[W-1] ^ v[W-1];
                b_d     = t_mag;
                md_d    = v_mag;
                rem_d   = '0;
                state_d = ST_DIV;
              end
            end
            default: begin
              tres_d  = v;
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_MUL: begin
        if (b_q[0]) begin
          tres_d = tres_q + a_q;
        end
        a_d   = {a_q[W-2:0], 1'b0};
        b_d   = {1'b0, b_q[W-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (last_step) begin
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        rem_d = ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
        b_d   = {b_q[W-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (last_step) begin
          state_d = ST_SGN;
        end
      end
      ST_SGN: begin
        tres_d  = neg_q ? (W'(0) - b_q) : b_q;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (cur_op_q != OP_EQ || out_free) begin
          state_d = ST_IDLE;
          case (cur_op_q) inside
            OP_MUL: begin
              term_d = tres_q;
              pmul_d = PMUL_MUL;
            end
            OP_DIV: begin
              term_d = tres_q;
              pmul_d = PMUL_DIV;
            end
            OP_ADD, OP_SUB: begin
              sum_d  = sum_n;
              sub_d  = (cur_op_q == OP_SUB);
              term_d = '0;
              pmul_d = PMUL_NONE;
            end
            default: begin
              out_valid_d            = 1'b1;
              out_item_d.result      = res_ext[OPERAND_W-1:0];
              out_item_d.div_by_zero = dz_q;
              sum_d                  = '0;
              sub_d                  = 1'b0;
              term_d                 = '0;
              pmul_d                 = PMUL_NONE;
              dz_d                   = 1'b0;
            end
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      sub_q       <= 1'b0;
      term_q      <= '0;
      pmul_q      <= PMUL_NONE;
      dz_q        <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      sub_q       <= sub_d;
      term_q      <= term_d;
      pmul_q      <= pmul_d;
      dz_q        <= dz_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_op_q   <= cur_op_d;
    tres_q     <= tres_d;
    a_q        <= a_d;
    b_q        <= b_d;
    rem_q      <= rem_d;
    md_q       <= md_d;
    neg_q      <= neg_d;
    out_item_q <= out_item_d;
  end

endmodule

`default_nettype wire

// File: rtl/core/precedence_expression_evaluator.sv
`default_nettype none

// Streaming evaluator for integer expressions given as (operand, mode) items,
// with multiply/divide binding tighter than add/subtract, left to right at
// each level. Arithmetic wraps at WordWidth bits; division truncates toward
// zero, and a zero divisor yields 0 and sets div_by_zero on the result. One
// result item leaves on each equals item; unknown modes are taken and dropped.
// Items enter a FifoDepth-entry queue, so the input keeps flowing while the
// evaluator works or the output is stalled, until the queue fills. The evaluator
// takes one item at a time from idle to a finish state; a pending multiply
// passes through a multiply state, and a pending divide through a divide state
// and a sign state unless the divisor is zero. The shared shift-add
// multiplier and restoring divider each retire one bit per cycle.
module precedence_expression_evaluator #(
  parameter int unsigned WordWidth = pee_pkg::WORD_WIDTH_DEF,
  parameter int unsigned FifoDepth = pee_pkg::FIFO_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pee_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pee_pkg::out_item_t out_item_o
);
  import pee_pkg::*;

  logic       push, pop;
  token_t     push_tok, pop_tok;
  fifo_stat_t fifo_stat;

  pee_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_tok_o  (push_tok)
  );

  pee_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_tok_i (push_tok),
    .pop_i      (pop),
    .pop_tok_o  (pop_tok),
    .stat_o     (fifo_stat)
  );

  pee_back #(
    .WordWidth (WordWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (!fifo_stat.empty),
    .tok_i       (pop_tok),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // the evaluator never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !fifo_stat.empty)
    else $error("pop from empty queue");

  // a stalled result item stays valid and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed or dropped");

  // nothing is pushed while the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !fifo_stat.full)
    else $error("push into full queue");

endmodule

`default_nettype wire

// File: tb/precedence_expression_evaluator_test.sv
`timescale 1ns / 1ps

module precedence_expression_evaluator_test;
  import pee_pkg::*;

  typedef struct packed {
    logic [OPERAND_W-1:0] operand;
    logic [MODE_W-1:0]    mode;
    logic                 typed;
    logic [OPERAND_W-1:0] result;
    logic                 div_by_zero;
  } token_row_t;

  localparam int unsigned OPENING_ROWS = 24;
  localparam int unsigned RANDOM_TOKENS = 1150;
  localparam int unsigned TAIL_CYCLES = 2 * WORD_WIDTH_DEF + 16;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  // predictor state
  logic [OPERAND_W-1:0] sum_acc = '0;
  logic                 sub_pending = 1'b0;
  logic [OPERAND_W-1:0] term_acc = '0;
  logic [1:0]           mul_pending = PMUL_NONE;
  logic                 zero_div_seen = 1'b0;

  out_item_t awaited_results[$];
  out_item_t head_result;
  int        mismatches = 0;
  int        stall_left = 0;
  logic      calm_q = 1'b0;

  // extremes, every operator, zero divisor, min / -1, truncation, wrap, unknown modes
  token_row_t opening_tokens [OPENING_ROWS] = '{
    '{32'd0,         MODE_EQ,  1'b1, 32'd0,         1'b0},
    '{32'd5,         MODE_DIV, 1'b0, 32'd0,         1'b0},
    '{32'd0,         MODE_EQ,  1'b1, 32'd0,         1'b1},
    '{32'h8000_0000, MODE_DIV, 1'b0, 32'd0,         1'b0},
    '{32'hffff_ffff, MODE_EQ,  1'b1, 32'h8000_0000, 1'b0},
    '{32'd7,         MODE_DIV, 1'b0, 32'd0,         1'b0},
    '{32'hffff_fffe, MODE_EQ,  1'b1, 32'hffff_fffd, 1'b0},
    '{32'h7fff_ffff, MODE_ADD, 1'b0, 32'd0,         1'b0},
    '{32'd1,         MODE_EQ,  1'b1, 32'h8000_0000, 1'b0},
    '{32'h7fff_ffff, MODE_MUL, 1'b0, 32'd0,         1'b0},
    '{32'd2,         MODE_EQ,  1'b1, 32'hffff_fffe, 1'b0},
    '{32'd3,         MODE_ADD, 1'b0, 32'd0,         1'b0},
    '{32'd123,       3'd5,     1'b0, 32'd0,         1'b0},
    '{32'hffff_ffff, 3'd7,     1'b0, 32'd0,         1'b0},
    '{32'd4,         MODE_EQ,  1'b1, 32'd7,         1'b0},
    '{32'd2,         MODE_ADD, 1'b0, 32'd0,         1'b0},
    '{32'd3,         MODE_MUL, 1'b0, 32'd0,         1'b0},
    '{32'd4,         MODE_SUB, 1'b0, 32'd0,         1'b0},
    '{32'd10,        MODE_DIV, 1'b0, 32'd0,         1'b0},
    '{32'd3,         MODE_EQ,  1'b0, 32'd0,         1'b0},
    '{32'd1,         MODE_DIV, 1'b0, 32'd0,         1'b0},
    '{32'd0,         MODE_MUL, 1'b0, 32'd0,         1'b0},
    '{32'd5,         MODE_ADD, 1'b0, 32'd0,         1'b0},
    '{32'd3,         MODE_EQ,  1'b1, 32'd3,         1'b1}
  };

  precedence_expression_evaluator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one; none while calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (calm_q || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic [OPERAND_W-1:0] pick_operand();
    int r;
    r = $urandom_range(9, 0);
    case (r)
      0: return '0;
      1: begin
        case ($urandom_range(3, 0))
          0: return '1;
          1: return 32'd1;
          2: return 32'h8000_0000;
          default: return 32'h7fff_ffff;
        endcase
      end
      2, 3, 4: return OPERAND_W'($signed($urandom_range(40, 0)) - 20);
      default: return $urandom;
    endcase
  endfunction

  // Advances the predictor by one token; returns 1 when an equals closes the expression.
  function automatic logic evaluate_token(input in_item_t tok, output out_item_t res);
    logic [OPERAND_W-1:0] v;
    logic [OPERAND_W-1:0] t;
    logic [OPERAND_W-1:0] s;
    logic [OPERAND_W:0]   mag_n;
    logic [OPERAND_W:0]   mag_d;
    logic [OPERAND_W:0]   quo;
    res = '0;
    if (tok.mode > MODE_EQ) return 1'b0;
    v = tok.operand;
    case (mul_pending)
      PMUL_MUL: t = term_acc * v;
      PMUL_DIV: begin
        if (v == '0) begin
          t = '0;
          zero_div_seen = 1'b1;
        end else begin
          mag_n = term_acc[OPERAND_W-1] ? -{1'b1, term_acc} : {1'b0, term_acc};
          mag_d = v[OPERAND_W-1] ? -{1'b1, v} : {1'b0, v};
          quo = mag_n / mag_d;
          t = quo[OPERAND_W-1:0];
          if (term_acc[OPERAND_W-1] != v[OPERAND_W-1]) t = -t;
        end
      end
      default: t = v;
    endcase
    if (tok.mode == MODE_MUL || tok.mode == MODE_DIV) begin
      term_acc = t;
      mul_pending = (tok.mode == MODE_MUL) ? PMUL_MUL : PMUL_DIV;
      return 1'b0;
    end
    s = sub_pending ? sum_acc - t : sum_acc + t;
    if (tok.mode == MODE_ADD || tok.mode == MODE_SUB) begin
      sum_acc = s;
      sub_pending = (tok.mode == MODE_SUB);
      term_acc = '0;
      mul_pending = PMUL_NONE;
      return 1'b0;
    end
    res.result = s;
    res.div_by_zero = zero_div_seen;
    sum_acc = '0;
    sub_pending = 1'b0;
    term_acc = '0;
    mul_pending = PMUL_NONE;
    zero_div_seen = 1'b0;
    return 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic feed_token(input in_item_t tok, input logic typed, input out_item_t typed_res);
    int        gap;
    out_item_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i = tok;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (evaluate_token(tok, pred)) awaited_results.push_back(typed ? typed_res : pred);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      stall_left = pick_gap();
      out_stall_i = (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none awaited: expected nothing, got result %0d div_by_zero %0b",
                 $time, out_item_o.result, out_item_o.div_by_zero);
      end else begin
        head_result = awaited_results.pop_front();
        if (out_item_o.result !== head_result.result) begin
          mismatches++;
          $display("%0t: result mismatch: expected %0d, got %0d",
                   $time, head_result.result, out_item_o.result);
        end
        if (out_item_o.div_by_zero !== head_result.div_by_zero) begin
          mismatches++;
          $display("%0t: div_by_zero mismatch: expected %0b, got %0b",
                   $time, head_result.div_by_zero, out_item_o.div_by_zero);
        end
      end
    end
  end

  initial begin
    in_item_t tok;
    int       sent;
    int       len;
    logic     paused;
    sent = 0;
    paused = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (opening_tokens[i]) begin
      tok.operand = opening_tokens[i].operand;
      tok.mode = opening_tokens[i].mode;
      feed_token(tok, opening_tokens[i].typed,
                 '{result: opening_tokens[i].result,
                   div_by_zero: opening_tokens[i].div_by_zero});
    end

    while (sent < RANDOM_TOKENS) begin
      if ($urandom_range(49, 0) == 0) calm_q = ~calm_q;
      if (!paused && sent >= RANDOM_TOKENS / 2) begin
        // hold off until the block has drained
        paused = 1'b1;
        in_valid_i = 1'b0;
        while (awaited_results.size() != 0) @(negedge clk_i);
      end
      len = ($urandom_range(7, 0) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(19, 0) == 0) begin
          // ignored mode, not counted
          tok.operand = $urandom;
          tok.mode = MODE_W'($urandom_range((1 << MODE_W) - 1, int'(MODE_EQ) + 1));
          feed_token(tok, 1'b0, '0);
        end
        tok.operand = pick_operand();
        tok.mode = (k == len - 1) ? MODE_EQ : MODE_W'($urandom_range(MODE_DIV, MODE_ADD));
        feed_token(tok, 1'b0, '0);
        sent++;
      end
    end

    in_valid_i = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("precedence_expression_evaluator_test passed");
    end else begin
      $display("precedence_expression_evaluator_test failed");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("precedence_expression_evaluator_test failed");
    $finish;
  end

endmodule
